@@ rtl/core/mtep_pkg.sv @@
// Shared types, codes and helpers of the MIDI track event parser.
package mtep_pkg;

  localparam int unsigned TimeBitsDefault = 32;
  localparam int unsigned LenBits         = 28;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_CMD  = 4'd4,
    PH_META_LEN  = 4'd5,
    PH_SYSEX_LEN = 4'd6,
    PH_SKIP      = 4'd7,
    PH_DONE      = 4'd8
  } phase_t;

  localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_PROGRAM  = 3'd2;
  localparam logic [2:0] KIND_END      = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_PROGRAM    = 4'hc;
  localparam logic [3:0] HI_PRESSURE   = 4'hd;
  localparam logic [3:0] HI_SYSTEM     = 4'hf;
  localparam logic [7:0] STATUS_META   = 8'hff;
  localparam logic [7:0] META_END      = 8'h2f;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [LenBits-1:0] TEMPO_LEN = LenBits'(3);
  localparam logic [2:0] VARLEN_MAX    = 3'd4;

  typedef struct packed {
    phase_t              phase;
    logic [7:0]          run_status;
    logic [LenBits-1:0]  length_accum;
    logic [2:0]          length_seen;
    logic [LenBits-1:0]  skip_remaining;
    logic [7:0]          status_latch;
    logic [7:0]          first_data;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:          PH_DELTA,
    run_status:     8'd0,
    length_accum:   '0,
    length_seen:    3'd0,
    skip_remaining: '0,
    status_latch:   8'd0,
    first_data:     8'd0
  };

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [3:0] channel;
    logic [7:0] note;
    logic [7:0] velocity;
    logic [7:0] program_res;
  } event_t;

  // Phase that follows a status byte.
  function automatic phase_t status_phase(input logic [7:0] st);
    phase_t ph;
    if (st == STATUS_META) begin
      ph = PH_META_CMD;
    end else if (st[7:4] == HI_SYSTEM) begin
      ph = PH_SYSEX_LEN;
    end else begin
      ph = PH_DATA1;
    end
    return ph;
  endfunction

  function automatic phase_t skip_phase(input logic [LenBits-1:0] n);
    return (n == '0) ? PH_DELTA : PH_SKIP;
  endfunction

endpackage

@@ rtl/core/mtep_decode.sv @@
// Next-state and event decode for one track byte.
module mtep_decode (
  input  logic [7:0]                      track_byte,
  input  logic                            start_track,
  input  mtep_pkg::parse_state_t          state_cur,
  output mtep_pkg::parse_state_t          state_next,
  output mtep_pkg::event_t                event_out,
  output logic                            time_add,
  output logic [mtep_pkg::LenBits-1:0]    time_delta
);

  mtep_pkg::parse_state_t cur;
  mtep_pkg::phase_t       eff_phase;
  logic [7:0]             eff_latch;
  logic [3:0]             hi;
  logic [3:0]             ch;
  logic [mtep_pkg::LenBits-1:0] vl_accum;
  logic [2:0]             vl_seen;
  logic                   vl_done;

  always_comb begin
    cur        = start_track ? mtep_pkg::STATE_RESET : state_cur;
    state_next = cur;
    event_out  = '0;
    time_add   = 1'b0;
    time_delta = '0;
    eff_phase  = cur.phase;
    eff_latch  = cur.status_latch;

    // A data byte where a status is expected reuses the running status.
    if (cur.phase == mtep_pkg::PH_STATUS && !track_byte[7] &&
        cur.run_status != 8'd0) begin
      state_next.status_latch = cur.run_status;
      state_next.length_accum = '0;
      state_next.length_seen  = 3'd0;
      eff_phase = mtep_pkg::status_phase(cur.run_status);
      eff_latch = cur.run_status;
    end

    hi       = eff_latch[7:4];
    ch       = eff_latch[3:0];
    vl_accum = {state_next.length_accum[mtep_pkg::LenBits-8:0], track_byte[6:0]};
    vl_seen  = state_next.length_seen + 3'd1;
    vl_done  = !track_byte[7] || (vl_seen >= mtep_pkg::VARLEN_MAX);

    unique case (eff_phase)
      mtep_pkg::PH_DELTA: begin
        state_next.length_accum = vl_accum;
        state_next.length_seen  = vl_seen;
        if (vl_done) begin
          time_add   = 1'b1;
          time_delta = vl_accum;
          state_next.length_accum = '0;
          state_next.length_seen  = 3'd0;
          state_next.phase        = mtep_pkg::PH_STATUS;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (track_byte[7]) begin
          state_next.run_status     = track_byte;
          state_next.status_latch   = track_byte;
          state_next.length_accum   = '0;
          state_next.length_seen    = 3'd0;
          state_next.phase          = mtep_pkg::status_phase(track_byte);
        end else begin
          state_next.phase = mtep_pkg::PH_DONE;
          event_out.valid  = 1'b1;
          event_out.kind   = mtep_pkg::KIND_ERROR;
        end
      end
      mtep_pkg::PH_DATA1: begin
        state_next.first_data = track_byte;
        if (hi == mtep_pkg::HI_PROGRAM) begin
          state_next.phase      = mtep_pkg::PH_DELTA;
          event_out.valid       = 1'b1;
          event_out.kind        = mtep_pkg::KIND_PROGRAM;
          event_out.channel     = ch;
          event_out.program_res = track_byte;
        end else if (hi == mtep_pkg::HI_PRESSURE) begin
          state_next.phase = mtep_pkg::PH_DELTA;
        end else begin
          state_next.phase = mtep_pkg::PH_DATA2;
        end
      end
      mtep_pkg::PH_DATA2: begin
        state_next.phase = mtep_pkg::PH_DELTA;
        if (hi == mtep_pkg::HI_NOTE_ON || hi == mtep_pkg::HI_NOTE_OFF) begin
          event_out.valid    = 1'b1;
          event_out.kind     = (hi == mtep_pkg::HI_NOTE_ON && track_byte != 8'd0) ?
                               mtep_pkg::KIND_NOTE_ON : mtep_pkg::KIND_NOTE_OFF;
          event_out.channel  = ch;
          event_out.note     = cur.first_data;
          event_out.velocity = track_byte;
        end
      end
      mtep_pkg::PH_META_CMD: begin
        state_next.first_data = track_byte;
        state_next.phase      = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN: begin
        if (cur.first_data == mtep_pkg::META_END) begin
          state_next.phase = mtep_pkg::PH_DONE;
          event_out.valid  = 1'b1;
          event_out.kind   = mtep_pkg::KIND_END;
        end else if (cur.first_data == mtep_pkg::META_TEMPO) begin
          // Tempo data is always three bytes, whatever the length byte says.
          state_next.skip_remaining = mtep_pkg::TEMPO_LEN;
          state_next.phase          = mtep_pkg::skip_phase(mtep_pkg::TEMPO_LEN);
        end else begin
          state_next.skip_remaining = mtep_pkg::LenBits'(track_byte);
          state_next.phase = mtep_pkg::skip_phase(mtep_pkg::LenBits'(track_byte));
        end
      end
      mtep_pkg::PH_SYSEX_LEN: begin
        state_next.length_accum = vl_accum;
        state_next.length_seen  = vl_seen;
        if (vl_done) begin
          state_next.skip_remaining = vl_accum;
          state_next.phase          = mtep_pkg::skip_phase(vl_accum);
          state_next.length_accum   = '0;
          state_next.length_seen    = 3'd0;
        end
      end
      mtep_pkg::PH_SKIP: begin
        state_next.skip_remaining = cur.skip_remaining - mtep_pkg::LenBits'(1);
        if (state_next.skip_remaining == '0) begin
          state_next.phase = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_DONE: begin
        state_next = cur;
      end
      default: begin
        state_next = cur;
      end
    endcase
  end

endmodule

@@ rtl/core/midi_track_event_parser_unit.sv @@
// MIDI track event parser: one track byte in per word, at most one event out per byte.
// Each accepted byte is fully decoded in the cycle it is taken, so the unit sustains one
// byte per clock; the event it causes appears on the master side on the next cycle and is
// held in an output register, so a new byte is taken whenever that register is empty or
// is being read. Delta times are added into a wrapping absolute time of TIME_BITS bits, of
// which the low 32 are reported. A byte with start_track set clears the parser first.
// After an end-of-track or an error word, bytes are consumed without effect until the
// next start.
module midi_track_event_parser_unit #(
  parameter int unsigned TIME_BITS = mtep_pkg::TimeBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // track_byte
  input  logic        s_tuser,   // start_track
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // event_time[31:0], channel, note, velocity, program_res
  output logic [2:0]  m_tuser    // kind
);

  localparam int unsigned SumBits = (TIME_BITS > mtep_pkg::LenBits) ?
                                    TIME_BITS : mtep_pkg::LenBits;
  localparam int unsigned OutBits = (TIME_BITS > 32) ? TIME_BITS : 32;

  mtep_pkg::parse_state_t state;
  mtep_pkg::parse_state_t state_next;
  mtep_pkg::event_t       event_next;
  logic                   time_add;
  logic [mtep_pkg::LenBits-1:0] time_delta;

  logic [TIME_BITS-1:0]   elapsed;
  logic [TIME_BITS-1:0]   elapsed_cur;
  logic [SumBits-1:0]     elapsed_sum;
  logic [OutBits-1:0]     elapsed_out;
  logic                   accept;

  logic [31:0] event_time;
  logic [3:0]  channel;
  logic [7:0]  note;
  logic [7:0]  velocity;
  logic [7:0]  program_res;
  logic [2:0]  kind;

  mtep_decode u_decode (
    .track_byte  (s_tdata),
    .start_track (s_tuser),
    .state_cur   (state),
    .state_next  (state_next),
    .event_out   (event_next),
    .time_add    (time_add),
    .time_delta  (time_delta)
  );

  assign s_tready    = !m_tvalid || m_tready;
  assign accept      = s_tvalid && s_tready;
  assign elapsed_cur = s_tuser ? '0 : elapsed;
  assign elapsed_sum = SumBits'(elapsed_cur) + SumBits'(time_delta);
  assign elapsed_out = OutBits'(elapsed_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mtep_pkg::STATE_RESET;
      elapsed  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
        if (time_add) begin
          elapsed <= elapsed_sum[TIME_BITS-1:0];
        end else begin
          elapsed <= elapsed_cur;
        end
      end
      if (s_tready) begin
        m_tvalid <= accept && event_next.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && event_next.valid) begin
      kind        <= event_next.kind;
      event_time  <= elapsed_out[31:0];
      channel     <= event_next.channel;
      note        <= event_next.note;
      velocity    <= event_next.velocity;
      program_res <= event_next.program_res;
    end
  end

  assign m_tdata = {4'd0, program_res, velocity, note, channel, event_time};
  assign m_tuser = kind;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the MIDI track event parser: streams track bytes, checks events.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Channel message kinds that the package does not name.
  localparam logic [3:0] HI_POLY_TOUCH = 4'ha;
  localparam logic [3:0] HI_CONTROL    = 4'hb;
  localparam logic [3:0] HI_BEND       = 4'he;
  localparam logic [7:0] SYSEX_START   = 8'hf0;
  localparam int         HOLD_CYCLES   = 200;
  localparam int         RANDOM_BYTES  = 700;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] ticks;
    logic [3:0]  chan;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [7:0]  prog;
  } midi_event_t;

  // Tracks the parser state byte by byte and keeps the events it must produce, oldest first.
  class midi_model_t;
    mtep_pkg::phase_t             ph;
    logic [7:0]                   run_status;
    logic [31:0]                  ticks;
    logic [mtep_pkg::LenBits-1:0] len_acc;
    int                           len_cnt;
    logic [mtep_pkg::LenBits-1:0] skip_left;
    logic [7:0]                   status_hold;
    logic [7:0]                   data0;
    midi_event_t                  expected_events[$];
    int                           mismatches;
    int                           byte_count;

    function new();
      clear();
      mismatches = 0;
      byte_count = 0;
    endfunction

    function void clear();
      ph          = mtep_pkg::PH_DELTA;
      run_status  = 8'd0;
      ticks       = 32'd0;
      len_acc     = '0;
      len_cnt     = 0;
      skip_left   = '0;
      status_hold = 8'd0;
      data0       = 8'd0;
    endfunction

    function void open_status(logic [7:0] st);
      status_hold = st;
      len_acc     = '0;
      len_cnt     = 0;
      if (st == mtep_pkg::STATUS_META) begin
        ph = mtep_pkg::PH_META_CMD;
      end else if (st[7:4] == mtep_pkg::HI_SYSTEM) begin
        ph = mtep_pkg::PH_SYSEX_LEN;
      end else begin
        ph = mtep_pkg::PH_DATA1;
      end
    endfunction

    function bit varlen_done(logic [7:0] b);
      len_acc = {len_acc[mtep_pkg::LenBits-8:0], b[6:0]};
      len_cnt++;
      return !b[7] || len_cnt >= mtep_pkg::VARLEN_MAX;
    endfunction

    function void begin_skip(logic [mtep_pkg::LenBits-1:0] n);
      skip_left = n;
      ph = (n == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
    endfunction

    function void post(logic [2:0] kind, logic [3:0] chan, logic [7:0] note,
                       logic [7:0] vel, logic [7:0] prog);
      midi_event_t e;
      e.kind  = kind;
      e.ticks = ticks;
      e.chan  = chan;
      e.note  = note;
      e.vel   = vel;
      e.prog  = prog;
      expected_events.insert(expected_events.size(), e);
    endfunction

    function void parse(logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] chan;
      hi   = status_hold[7:4];
      chan = status_hold[3:0];
      case (ph)
        mtep_pkg::PH_DELTA: begin
          if (varlen_done(b)) begin
            ticks   = ticks + 32'(len_acc);
            len_acc = '0;
            len_cnt = 0;
            ph      = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (b[7]) begin
            run_status = b;
            open_status(b);
          end else if (run_status == 8'd0) begin
            ph = mtep_pkg::PH_DONE;
            post(mtep_pkg::KIND_ERROR, 4'd0, 8'd0, 8'd0, 8'd0);
          end else begin
            // A data byte here reuses the running status and is then parsed as its first byte.
            open_status(run_status);
            parse(b);
          end
        end
        mtep_pkg::PH_DATA1: begin
          data0 = b;
          if (hi == mtep_pkg::HI_PROGRAM) begin
            ph = mtep_pkg::PH_DELTA;
            post(mtep_pkg::KIND_PROGRAM, chan, 8'd0, 8'd0, b);
          end else begin
            ph = (hi == mtep_pkg::HI_PRESSURE) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
          end
        end
        mtep_pkg::PH_DATA2: begin
          ph = mtep_pkg::PH_DELTA;
          if (hi == mtep_pkg::HI_NOTE_ON) begin
            post((b == 8'd0) ? mtep_pkg::KIND_NOTE_OFF : mtep_pkg::KIND_NOTE_ON,
                 chan, data0, b, 8'd0);
          end else if (hi == mtep_pkg::HI_NOTE_OFF) begin
            post(mtep_pkg::KIND_NOTE_OFF, chan, data0, b, 8'd0);
          end
        end
        mtep_pkg::PH_META_CMD: begin
          data0 = b;
          ph    = mtep_pkg::PH_META_LEN;
        end
        mtep_pkg::PH_META_LEN: begin
          if (data0 == mtep_pkg::META_END) begin
            ph = mtep_pkg::PH_DONE;
            post(mtep_pkg::KIND_END, 4'd0, 8'd0, 8'd0, 8'd0);
          end else if (data0 == mtep_pkg::META_TEMPO) begin
            begin_skip(mtep_pkg::TEMPO_LEN);
          end else begin
            begin_skip(mtep_pkg::LenBits'(b));
          end
        end
        mtep_pkg::PH_SYSEX_LEN: begin
          if (varlen_done(b)) begin
            begin_skip(len_acc);
            len_acc = '0;
            len_cnt = 0;
          end
        end
        mtep_pkg::PH_SKIP: begin
          skip_left = skip_left - mtep_pkg::LenBits'(1);
          if (skip_left == '0) begin
            ph = mtep_pkg::PH_DELTA;
          end
        end
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic first);
      byte_count++;
      if (first) begin
        clear();
      end
      if (ph == mtep_pkg::PH_DONE) begin
        return;
      end
      parse(b);
    endfunction

    function void complain(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: event %s mismatch: expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void match_event(logic [2:0] kind, logic [63:0] word);
      midi_event_t e;
      if (expected_events.size() == 0) begin
        complain("arrived with none pending;", 64'd0, word);
        return;
      end
      e = expected_events.pop_front();
      if (kind !== e.kind)           complain("kind", e.kind, kind);
      if (word[31:0] !== e.ticks)    complain("event_time", e.ticks, word[31:0]);
      if (word[35:32] !== e.chan)    complain("channel", e.chan, word[35:32]);
      if (word[43:36] !== e.note)    complain("note", e.note, word[43:36]);
      if (word[51:44] !== e.vel)     complain("velocity", e.vel, word[51:44]);
      if (word[59:52] !== e.prog)    complain("program", e.prog, word[59:52]);
      if (word[63:60] !== 4'd0)      complain("padding", 64'd0, word[63:60]);
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;

  midi_model_t parser_model = new();

  bit         new_track = 1'b0;
  bit         tx_calm   = 1'b0;
  bit         rx_calm   = 1'b0;
  bit         hold_req  = 1'b0;
  int         hold_left = 0;
  int         rx_gap    = 0;
  logic [7:0] last_status = 8'd0;

  midi_track_event_parser_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] data_value();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127));
  endfunction

  // Event consumer: random stalls, calm stretches and one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_calm) begin
      m_tready <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      parser_model.match_event(m_tuser, m_tdata);
    end
  end

  task automatic put(input logic [7:0] b);
    int   gap;
    logic first;
    gap       = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    first     = new_track;
    new_track = 1'b0;
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parser_model.take_byte(b, first);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (parser_model.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Variable-length quantity, optionally padded with leading empty groups.
  task automatic put_varlen(input logic [mtep_pkg::LenBits-1:0] v, input bit pad);
    int n;
    n = 1;
    while (n < 4 && (v >> (7 * n)) != 0) n++;
    if (pad) begin
      n = $urandom_range(n, 4);
    end
    for (int i = n - 1; i >= 0; i--) begin
      put({(i != 0), 7'(v >> (7 * i))});
    end
  endtask

  task automatic random_delta(input bit big);
    int                           r;
    logic [mtep_pkg::LenBits-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      // Every byte says more follows; the parser must still stop after four.
      repeat (4) put(8'($urandom_range(128, 255)));
    end else begin
      if (big) begin
        v = mtep_pkg::LenBits'($urandom_range(32'h0f00_0000, 32'h0fff_ffff));
      end else if (r < 50) begin
        v = '0;
      end else if (r < 80) begin
        v = mtep_pkg::LenBits'($urandom_range(1, 127));
      end else if (r < 92) begin
        v = mtep_pkg::LenBits'($urandom_range(128, 16383));
      end else begin
        v = mtep_pkg::LenBits'($urandom_range(16384, 32'h0fff_ffff));
      end
      put_varlen(v, $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic channel_event(input logic [3:0] hi);
    logic [7:0] st;
    logic [7:0] d;
    bit         reuse;
    reuse = (last_status[7:4] == hi) && $urandom_range(0, 2) != 0;
    if (!reuse) begin
      st = {hi, 4'($urandom_range(0, 15))};
      put(st);
      last_status = st;
    end
    d = data_value();
    if (reuse) begin
      d[7] = 1'b0;
    end
    put(d);
    if (hi != mtep_pkg::HI_PROGRAM && hi != mtep_pkg::HI_PRESSURE) begin
      put((hi == mtep_pkg::HI_NOTE_ON && $urandom_range(0, 4) == 0) ? 8'd0 : data_value());
    end
  endtask

  task automatic meta_event(input logic [7:0] cmd);
    int len;
    if (!(last_status == mtep_pkg::STATUS_META && $urandom_range(0, 1) == 0)) begin
      put(mtep_pkg::STATUS_META);
      last_status = mtep_pkg::STATUS_META;
    end
    put(cmd);
    if (cmd == mtep_pkg::META_TEMPO) begin
      put(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd3);
      repeat (3) put(8'($urandom_range(0, 255)));
    end else if (cmd == mtep_pkg::META_END) begin
      put(8'($urandom_range(0, 255)));
    end else begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
      put(8'(len));
      repeat (len) put(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic sysex_event();
    logic [7:0] st;
    bit         reuse;
    int         len;
    reuse = last_status[7:4] == mtep_pkg::HI_SYSTEM && last_status != mtep_pkg::STATUS_META &&
            $urandom_range(0, 1) == 0;
    if (!reuse) begin
      st = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hf1, 8'hfe)) : SYSEX_START;
      put(st);
      last_status = st;
    end
    len = $urandom_range(0, 8);
    put_varlen(mtep_pkg::LenBits'(len), !reuse && $urandom_range(0, 1) == 0);
    repeat (len) put(8'($urandom_range(0, 255)));
  endtask

  task automatic random_track();
    int events;
    int r;
    bit big;
    new_track   = 1'b1;
    last_status = 8'd0;
    tx_calm     = $urandom_range(0, 3) == 0;
    rx_calm     = $urandom_range(0, 3) == 0;
    // Long deltas make the absolute time wrap within one track.
    big    = $urandom_range(0, 5) == 0;
    events = big ? $urandom_range(18, 30) : $urandom_range(3, 20);
    if ($urandom_range(0, 9) == 0) begin
      random_delta(1'b0);
      put(8'($urandom_range(0, 127)));
      repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
      return;
    end
    repeat (events) begin
      random_delta(big);
      r = $urandom_range(0, 99);
      if (r < 22)      channel_event(mtep_pkg::HI_NOTE_ON);
      else if (r < 34) channel_event(mtep_pkg::HI_NOTE_OFF);
      else if (r < 42) channel_event(mtep_pkg::HI_PROGRAM);
      else if (r < 48) channel_event(mtep_pkg::HI_PRESSURE);
      else if (r < 54) channel_event(HI_POLY_TOUCH);
      else if (r < 62) channel_event(HI_CONTROL);
      else if (r < 70) channel_event(HI_BEND);
      else if (r < 78) meta_event(mtep_pkg::META_TEMPO);
      else if (r < 86) meta_event(8'($urandom_range(0, 127)));
      else if (r < 94) sysex_event();
      else             put(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) != 0) begin
      random_delta(big);
      meta_event(mtep_pkg::META_END);
      repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int goal;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    rx_calm   = 1'b1;
    new_track = 1'b1;
    // Note-on with the largest data values on the highest channel.
    put(8'h00); put({mtep_pkg::HI_NOTE_ON, 4'hf}); put(8'h7f); put(8'h7f);
    // Longest delta, cut off after four bytes, then a running note-on with zero velocity.
    repeat (4) put(8'hff);
    put(8'h00); put(8'h00);
    put(8'h00); put({mtep_pkg::HI_NOTE_OFF, 4'h0}); put(8'h3c); put(8'hff);
    put(8'h00); put({mtep_pkg::HI_PROGRAM, 4'h5}); put(8'h80);
    // Sysex of length zero goes straight back to a delta time.
    put(8'h00); put(SYSEX_START); put(8'h00);
    // Tempo always drops three bytes, whatever its length byte says.
    put(8'h00); put(mtep_pkg::STATUS_META); put(mtep_pkg::META_TEMPO); put(8'h00);
    repeat (3) put(8'h5a);
    put(8'h00); put(mtep_pkg::STATUS_META); put(mtep_pkg::META_END); put(8'h00);
    put(8'h11);
    // A data byte before any status is an error.
    new_track = 1'b1;
    put(8'h00); put(8'h40);
    wait_drain();

    // Consumer stalls for a long stretch while notes keep coming in back to back.
    tx_calm     = 1'b1;
    rx_calm     = 1'b0;
    hold_req    = 1'b1;
    new_track   = 1'b1;
    last_status = 8'd0;
    repeat (30) begin
      put(8'h00);
      channel_event(mtep_pkg::HI_NOTE_ON);
    end
    tx_calm = 1'b0;
    wait_drain();

    goal = parser_model.byte_count + RANDOM_BYTES;
    while (parser_model.byte_count < goal) random_track();
    wait_drain();

    if (parser_model.mismatches == 0 && parser_model.expected_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
